/* rtl/mdiomm_pkg.sv */
// shared types and constants for the mdio management master
`default_nettype none

package mdiomm_pkg;

    // command codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_WRITE_FRAME = 3'd1,
        CMD_READ_FRAME  = 3'd2,
        CMD_CLEAR_DONE  = 3'd3,
        CMD_READ_STATUS = 3'd4
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MDC_DIVIDER  = 2'd0,
        CFG_HOLD_CYCLES  = 2'd1,
        CFG_PREAMBLE_OFF = 2'd2
    } cfg_index_t;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_DIV_W    = 6;
    localparam int HOLD_W       = 3;
    localparam int HOLD_CNT_W   = 4;
    localparam int SEQ_W        = 7;
    localparam int CAPTURE_W    = 16;

    // sequence positions: preamble 0..31, frame 32..63
    localparam logic [SEQ_W-1:0] SEQ_FRAME_START = 7'd32;
    localparam logic [SEQ_W-1:0] SEQ_RELEASE     = 7'd47;
    localparam logic [SEQ_W-1:0] SEQ_DATA        = 7'd48;
    localparam logic [SEQ_W-1:0] SEQ_END         = 7'd64;

    // frame bit that marks a read opcode
    localparam int FRAME_READ_BIT = 29;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;

    // one result word, mdc in the lowest bit
    typedef struct packed {
        logic        busy_res;
        logic        done_flag;
        logic [31:0] read_value;
        logic        mdio_drive;
        logic        mdio_out;
        logic        mdc;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

/* rtl/mdiomm_engine.sv */
// mdc divider, frame shifter and frame register of the mdio master
`default_nettype none

module mdiomm_engine #(
    parameter int DIVIDER_BITS = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step_en,
    input  wire mdiomm_pkg::cmd_t                  cmd,
    input  wire logic [31:0]                       frame_word,
    input  wire logic                              mdio_in,
    input  wire logic [DIVIDER_BITS-1:0]           divider,
    input  wire logic [mdiomm_pkg::HOLD_W-1:0]     hold_cycles,
    input  wire logic                              preamble_off,
    output mdiomm_pkg::result_t                    result_next
);

    // part of the state that one bit advance touches
    typedef struct packed {
        logic [31:0]                   fr;
        logic [31:0]                   sr;
        logic [mdiomm_pkg::SEQ_W-1:0]  bc;
        logic                          busy;
        logic                          done;
    } adv_t;

    logic [31:0]                         frame_reg,   frame_next;
    logic [31:0]                         shift_reg,   shift_next;
    logic [mdiomm_pkg::SEQ_W-1:0]        bit_count_reg, bit_count_next;
    logic [DIVIDER_BITS-1:0]             phase_reg,   phase_next;
    logic                                level_reg,   level_next;
    logic [mdiomm_pkg::HOLD_CNT_W-1:0]   hold_count_reg, hold_count_next;
    logic                                busy_reg,    busy_next;
    logic                                done_reg,    done_next;
    logic [mdiomm_pkg::CAPTURE_W-1:0]    capture_reg, capture_next;

    // move to the next sequence bit, closing the frame at its end
    function automatic adv_t advance(input adv_t a, input logic [15:0] cap);
        adv_t r;
        r = a;
        if (a.bc >= mdiomm_pkg::SEQ_FRAME_START) begin
            r.sr = {a.sr[30:0], 1'b0};
        end
        r.bc = a.bc + 7'd1;
        if (r.bc >= mdiomm_pkg::SEQ_END) begin
            r.busy = 1'b0;
            r.done = 1'b1;
            if (a.fr[mdiomm_pkg::FRAME_READ_BIT]) begin
                r.fr = {a.fr[31:16], cap};
            end
        end
        return r;
    endfunction

    // next state and result of one word
    always_comb begin
        adv_t        st;
        logic        rising;
        logic [31:0] rv;
        logic        drive;
        logic        bit_out;

        st              = '{fr: frame_reg, sr: shift_reg, bc: bit_count_reg,
                            busy: busy_reg, done: done_reg};
        phase_next      = phase_reg;
        level_next      = level_reg;
        hold_count_next = hold_count_reg;
        capture_next    = capture_reg;
        rising          = 1'b0;
        rv              = '0;

        case (cmd)
            mdiomm_pkg::CMD_TICK: begin
                if (divider == '0) begin
                    phase_next = '0;
                    level_next = 1'b0;
                end else begin
                    // mdc divider
                    if (phase_reg >= divider) begin
                        phase_next = '0;
                        level_next = ~level_reg;
                        rising     = ~level_reg;
                    end else begin
                        phase_next = phase_reg + DIVIDER_BITS'(1);
                    end
                    // shifter
                    if (busy_reg) begin
                        if (rising) begin
                            if (hold_count_reg != '0) begin
                                st              = advance(st, capture_reg);
                                hold_count_next = '0;
                            end
                            if (st.busy) begin
                                if (st.fr[mdiomm_pkg::FRAME_READ_BIT] &&
                                    st.bc >= mdiomm_pkg::SEQ_DATA) begin
                                    capture_next = {capture_reg[14:0], mdio_in};
                                end
                                hold_count_next = {1'b0, hold_cycles} + 4'd1;
                            end
                        end else if (hold_count_reg != '0) begin
                            hold_count_next = hold_count_reg - 4'd1;
                            if (hold_count_next == '0) begin
                                st = advance(st, capture_reg);
                            end
                        end
                    end
                end
            end
            mdiomm_pkg::CMD_WRITE_FRAME: begin
                if (!busy_reg) begin
                    st.fr           = frame_word;
                    st.sr           = frame_word;
                    st.bc           = preamble_off ? mdiomm_pkg::SEQ_FRAME_START : '0;
                    st.busy         = 1'b1;
                    hold_count_next = '0;
                    capture_next    = '0;
                end
            end
            mdiomm_pkg::CMD_READ_FRAME: begin
                rv = frame_reg;
            end
            mdiomm_pkg::CMD_CLEAR_DONE: begin
                if (frame_word[0]) begin
                    st.done = 1'b0;
                end
            end
            mdiomm_pkg::CMD_READ_STATUS: begin
                rv = {29'd0, level_reg, busy_reg, done_reg};
            end
            default: begin
            end
        endcase

        frame_next     = st.fr;
        shift_next     = st.sr;
        bit_count_next = st.bc;
        busy_next      = st.busy;
        done_next      = st.done;

        // pin drive: released from the second turnaround bit of a read
        drive   = st.busy && !(st.fr[mdiomm_pkg::FRAME_READ_BIT] &&
                               st.bc >= mdiomm_pkg::SEQ_RELEASE);
        bit_out = 1'b1;
        if (drive && st.bc >= mdiomm_pkg::SEQ_FRAME_START) begin
            bit_out = st.sr[31];
        end

        result_next.mdc        = level_next;
        result_next.mdio_out   = bit_out;
        result_next.mdio_drive = drive;
        result_next.read_value = rv;
        result_next.done_flag  = st.done;
        result_next.busy_res   = st.busy;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg      <= '0;
            shift_reg      <= '0;
            bit_count_reg  <= '0;
            phase_reg      <= '0;
            level_reg      <= 1'b0;
            hold_count_reg <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            capture_reg    <= '0;
        end else if (step_en) begin
            frame_reg      <= frame_next;
            shift_reg      <= shift_next;
            bit_count_reg  <= bit_count_next;
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            hold_count_reg <= hold_count_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            capture_reg    <= capture_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mdio_management_master_core.sv */
// top level of the mdio management master: config registers and result buffer
`default_nettype none

// MDIO management master. Each input word carries a command in tuser: a tick
// advances the MDC divider and the frame shifter, a write while not busy loads
// a 32-bit clause 22/45 frame word and starts it (preamble of 32 ones unless
// preamble_off), a read returns the frame register (with read data in its low
// half once a read frame is done), clear done drops the done flag when data
// bit 0 is set, and read status returns {mdc, busy, done}. Every input word
// gives exactly one result word with the MDC level, the MDIO output and drive
// enable, the read value and the flags after that word. One word is accepted
// per clock: the state update is a single combinational step into the state
// registers, and results go to an output register backed by a one-word skid
// buffer, so s_tready only drops when two results wait. MDC half period is
// mdc_divider+1 tick words; a divider of zero holds MDC low.
module mdio_management_master_core #(
    parameter int DIVIDER_BITS = 6
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [mdiomm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mdiomm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    // frame_word [31:0], mdio_in [32], zero [39:33]
    input  wire logic [mdiomm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd [2:0]
    input  wire logic [mdiomm_pkg::IN_TUSER_W-1:0]     s_tuser,
    // result words
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // mdc [0], mdio_out [1], mdio_drive [2], read_value [34:3],
    // done_flag [35], busy_res [36], zero [39:37]
    output      logic [mdiomm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [DIVIDER_BITS-1:0]           divider_reg;
    logic [mdiomm_pkg::HOLD_W-1:0]     hold_cycles_reg;
    logic                              preamble_off_reg;
    logic [DIVIDER_BITS+mdiomm_pkg::CFG_DIV_W-1:0] divider_wide;

    mdiomm_pkg::result_t               result_next;
    mdiomm_pkg::result_t               main_reg;
    mdiomm_pkg::result_t               skid_reg;
    logic                              main_valid_reg;
    logic                              skid_valid_reg;
    logic                              step_en;
    logic                              take;

    assign cfg_ready = 1'b1;
    assign divider_wide = {{DIVIDER_BITS{1'b0}}, cfg_data[mdiomm_pkg::CFG_DIV_W-1:0]};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg      <= '0;
            hold_cycles_reg  <= '0;
            preamble_off_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (mdiomm_pkg::cfg_index_t'(cfg_index))
                mdiomm_pkg::CFG_MDC_DIVIDER: begin
                    divider_reg <= divider_wide[DIVIDER_BITS-1:0];
                end
                mdiomm_pkg::CFG_HOLD_CYCLES: begin
                    hold_cycles_reg <= cfg_data[mdiomm_pkg::HOLD_W-1:0];
                end
                mdiomm_pkg::CFG_PREAMBLE_OFF: begin
                    preamble_off_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign step_en  = s_tvalid & s_tready;
    assign take     = main_valid_reg & m_tready;

    mdiomm_engine #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .cmd          (mdiomm_pkg::cmd_t'(s_tuser)),
        .frame_word   (s_tdata[31:0]),
        .mdio_in      (s_tdata[32]),
        .divider      (divider_reg),
        .hold_cycles  (hold_cycles_reg),
        .preamble_off (preamble_off_reg),
        .result_next  (result_next)
    );

    // output register with one-word skid buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (step_en) begin
                if (!main_valid_reg || take) begin
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (take) begin
                main_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            if (!main_valid_reg || take) begin
                main_reg <= result_next;
            end else begin
                skid_reg <= result_next;
            end
        end else if (take && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(mdiomm_pkg::OUT_TDATA_W - mdiomm_pkg::RESULT_W){1'b0}}, main_reg};

endmodule

`default_nettype wire
